[rtl/tcf_pkg.sv]
// Shared types and codes for the two-class FIFO with oldest-first dequeue.
`timescale 1ns / 1ps
`default_nettype none
package tcf_pkg;

  localparam logic [1:0] CMD_ENQ    = 2'd0;
  localparam logic [1:0] CMD_DEQ0   = 2'd1;
  localparam logic [1:0] CMD_DEQ1   = 2'd2;
  localparam logic [1:0] CMD_OLDEST = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  // Decoded operation handed from the front part to the back part.
  // cls is the enqueue class, or the class asked for by a plain dequeue.
  typedef struct packed {
    logic enq;
    logic oldest;
    logic cls;
  } op_t;

endpackage
`default_nettype wire

[rtl/tcf_in_if.sv]
// Input channel: command items with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tcf_in_if #(
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic                    item_class;
  logic [PAYLOAD_BITS-1:0] payload_in;

  modport source (output valid, command, item_class, payload_in, input ready);
  modport sink   (input valid, command, item_class, payload_in, output ready);
endinterface
`default_nettype wire

[rtl/tcf_out_if.sv]
// Result channel: one result item per command, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tcf_out_if #(
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [PAYLOAD_BITS-1:0] payload_out;
  logic                    class_out;
  logic [1:0]              status;

  modport source (output valid, payload_out, class_out, status, input ready);
  modport sink   (input valid, payload_out, class_out, status, output ready);
endinterface
`default_nettype wire

[rtl/tcf_front.sv]
// Front part: accepts command items, decodes them and buffers two of them.
`timescale 1ns / 1ps
`default_nettype none
module tcf_front #(
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  tcf_in_if.sink                       in_ch,
  output      logic                    op_valid,
  input  wire logic                    op_ready,
  output      tcf_pkg::op_t            op,
  output      logic [PAYLOAD_BITS-1:0] op_payload
);

  tcf_pkg::op_t            slot_op_r  [2];
  logic [PAYLOAD_BITS-1:0] slot_pay_r [2];
  logic                    wr_ptr_r, wr_ptr_nxt;
  logic                    rd_ptr_r, rd_ptr_nxt;
  logic [1:0]              fill_r, fill_nxt;
  tcf_pkg::op_t            dec;
  logic                    push, pop;

  always_comb begin
    dec = '0;
    unique case (in_ch.command)
      tcf_pkg::CMD_ENQ: begin
        dec.enq = 1'b1;
        dec.cls = in_ch.item_class;
      end
      tcf_pkg::CMD_DEQ0:   dec.cls = 1'b0;
      tcf_pkg::CMD_DEQ1:   dec.cls = 1'b1;
      tcf_pkg::CMD_OLDEST: dec.oldest = 1'b1;
      default:             dec = '0;
    endcase
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign op_valid    = (fill_r != 2'd0);
  assign pop         = op_valid && op_ready;
  assign op          = slot_op_r[rd_ptr_r];
  assign op_payload  = slot_pay_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_op_r[wr_ptr_r]  <= dec;
      slot_pay_r[wr_ptr_r] <= in_ch.payload_in;
    end
  end

endmodule
`default_nettype wire

[rtl/tcf_back.sv]
// Back part: the two class stores, their pointers, the arrival stamp and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tcf_back #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int STAMP_BITS   = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    op_valid,
  output      logic                    op_ready,
  input  wire tcf_pkg::op_t            op,
  input  wire logic [PAYLOAD_BITS-1:0] op_payload,
  tcf_out_if.source                    out_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = PAYLOAD_BITS + STAMP_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [EW-1:0] store0 [QUEUE_DEPTH];
  logic [EW-1:0] store1 [QUEUE_DEPTH];
  logic [EW-1:0] rd0_r, rd1_r;

  logic                    state_r, state_nxt;
  tcf_pkg::op_t            op_r, op_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [AW-1:0]           head0_r, head0_nxt, tail0_r, tail0_nxt;
  logic [AW-1:0]           head1_r, head1_nxt, tail1_r, tail1_nxt;
  logic [CW-1:0]           cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [STAMP_BITS-1:0]   stamp_r, stamp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PAYLOAD_BITS-1:0] out_payload_r, out_payload_nxt;
  logic                    out_class_r, out_class_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  logic                  wr0, wr1, take, sel, have0, have1, full_cls;
  logic [STAMP_BITS-1:0] stamp_diff;

  assign op_ready           = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.payload_out = out_payload_r;
  assign out_ch.class_out   = out_class_r;
  assign out_ch.status      = out_status_r;

  assign have0      = (cnt0_r != '0);
  assign have1      = (cnt1_r != '0);
  // Head 0 is older when stamp1 - stamp0 lies in the lower half of the stamp ring.
  assign stamp_diff = rd1_r[PAYLOAD_BITS +: STAMP_BITS] - rd0_r[PAYLOAD_BITS +: STAMP_BITS];
  assign full_cls   = op_r.cls ? (cnt1_r == CW'(QUEUE_DEPTH)) : (cnt0_r == CW'(QUEUE_DEPTH));
  assign take       = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (!op_r.oldest) begin
      sel = op_r.cls;
    end else if (have0 && have1) begin
      sel = stamp_diff[STAMP_BITS-1];
    end else begin
      sel = !have0 && have1;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    pay_nxt         = pay_r;
    head0_nxt       = head0_r;
    tail0_nxt       = tail0_r;
    head1_nxt       = head1_r;
    tail1_nxt       = tail1_r;
    cnt0_nxt        = cnt0_r;
    cnt1_nxt        = cnt1_r;
    stamp_nxt       = stamp_r;
    out_valid_nxt   = out_valid_r;
    out_payload_nxt = out_payload_r;
    out_class_nxt   = out_class_r;
    out_status_nxt  = out_status_r;
    wr0             = 1'b0;
    wr1             = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          op_nxt    = op;
          pay_nxt   = op_payload;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (take) begin
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_payload_nxt = '0;
          if (op_r.enq) begin
            out_class_nxt = op_r.cls;
            if (full_cls) begin
              out_status_nxt = tcf_pkg::STS_FULL;
            end else begin
              out_status_nxt = tcf_pkg::STS_OK;
              stamp_nxt      = stamp_r + STAMP_BITS'(1);
              if (op_r.cls) begin
                wr1       = 1'b1;
                tail1_nxt = wrap_inc(tail1_r);
                cnt1_nxt  = cnt1_r + CW'(1);
              end else begin
                wr0       = 1'b1;
                tail0_nxt = wrap_inc(tail0_r);
                cnt0_nxt  = cnt0_r + CW'(1);
              end
            end
          end else begin
            out_class_nxt = sel;
            if (sel ? !have1 : !have0) begin
              out_status_nxt = tcf_pkg::STS_EMPTY;
            end else begin
              out_status_nxt = tcf_pkg::STS_OK;
              if (sel) begin
                out_payload_nxt = rd1_r[PAYLOAD_BITS-1:0];
                head1_nxt       = wrap_inc(head1_r);
                cnt1_nxt        = cnt1_r - CW'(1);
              end else begin
                out_payload_nxt = rd0_r[PAYLOAD_BITS-1:0];
                head0_nxt       = wrap_inc(head0_r);
                cnt0_nxt        = cnt0_r - CW'(1);
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head0_r     <= '0;
      tail0_r     <= '0;
      head1_r     <= '0;
      tail1_r     <= '0;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head0_r     <= head0_nxt;
      tail0_r     <= tail0_nxt;
      head1_r     <= head1_nxt;
      tail1_r     <= tail1_nxt;
      cnt0_r      <= cnt0_nxt;
      cnt1_r      <= cnt1_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    pay_r         <= pay_nxt;
    out_payload_r <= out_payload_nxt;
    out_class_r   <= out_class_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Head entries are fetched every cycle; each item passes idle before execute,
  // so the fetch always sees the pointers and writes of the previous item.
  always_ff @(posedge clk) begin
    if (wr0) begin
      store0[tail0_r] <= {stamp_r, pay_r};
    end
    rd0_r <= store0[head0_r];
  end

  always_ff @(posedge clk) begin
    if (wr1) begin
      store1[tail1_r] <= {stamp_r, pay_r};
    end
    rd1_r <= store1[head1_r];
  end

endmodule
`default_nettype wire

[rtl/two_class_fifo_oldest_first_top.sv]
// Top level of the two-class FIFO with oldest-first dequeue.
//
// Two FIFOs of QUEUE_DEPTH entries, one per class, share an arrival stamp of
// STAMP_BITS bits. Each command item yields exactly one result item: enqueue
// (status ok, or full when the class is full and the item is dropped), dequeue
// from class 0 or 1, or dequeue of the older head (class 0 wins ties; status
// empty when nothing can be taken). The front part decodes items into a
// two-entry queue and keeps taking them while the back part works. The back
// part handles each item in an idle state, which fetches both head entries
// from the class store memories (registered read), then an execute state
// that updates pointers and loads the result register; it takes no new item
// until that one is through. A result waiting in the output register holds
// the back part; the front queue then fills and the input stalls at two items.
`timescale 1ns / 1ps
`default_nettype none
module two_class_fifo_oldest_first_top #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int STAMP_BITS   = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tcf_in_if.sink    in_ch,
  tcf_out_if.source out_ch
);

  logic                    op_valid;
  logic                    op_ready;
  tcf_pkg::op_t            op;
  logic [PAYLOAD_BITS-1:0] op_payload;

  tcf_front #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .op_payload(op_payload)
  );

  tcf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .op_payload(op_payload),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

[tb/tcf_checker.sv]
// Result checker for the two-class FIFO: predicts every result item and compares it.
`timescale 1ns / 1ps
module tcf_checker #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int STAMP_BITS   = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic [1:0]              in_command,
  input  wire logic                    in_item_class,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload_in,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic [PAYLOAD_BITS-1:0] out_payload_out,
  input  wire logic                    out_class_out,
  input  wire logic [1:0]              out_status,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] tag;
    logic                    cls;
    logic [1:0]              status;
  } result_t;

  // Shadow of both class queues; index 0 is the first class, 1 the second.
  logic [PAYLOAD_BITS-1:0] tag_mem   [2][QUEUE_DEPTH];
  logic [STAMP_BITS-1:0]   stamp_mem [2][QUEUE_DEPTH];
  int                      head_ptr  [2];
  int                      tail_ptr  [2];
  int                      occupancy [2];
  logic [STAMP_BITS-1:0]   next_stamp;
  result_t                 expected_results[$];

  function automatic result_t pop_head(input logic cls);
    result_t r;
    r.cls    = cls;
    r.tag    = '0;
    r.status = tcf_pkg::STS_EMPTY;
    if (occupancy[cls] != 0) begin
      r.tag         = tag_mem[cls][head_ptr[cls]];
      r.status      = tcf_pkg::STS_OK;
      head_ptr[cls] = (head_ptr[cls] + 1) % QUEUE_DEPTH;
      occupancy[cls]--;
    end
    return r;
  endfunction

  function automatic result_t run_command(input logic [1:0] cmd, input logic cls,
                                          input logic [PAYLOAD_BITS-1:0] tag);
    result_t               r;
    logic [STAMP_BITS-1:0] stamp_gap;
    r = '0;
    case (cmd)
      tcf_pkg::CMD_ENQ: begin
        r.cls = cls;
        if (occupancy[cls] >= QUEUE_DEPTH) begin
          r.status = tcf_pkg::STS_FULL;
        end else begin
          tag_mem[cls][tail_ptr[cls]]   = tag;
          stamp_mem[cls][tail_ptr[cls]] = next_stamp;
          tail_ptr[cls] = (tail_ptr[cls] + 1) % QUEUE_DEPTH;
          occupancy[cls]++;
          next_stamp = next_stamp + STAMP_BITS'(1);
          r.status   = tcf_pkg::STS_OK;
        end
      end
      tcf_pkg::CMD_DEQ0: r = pop_head(1'b0);
      tcf_pkg::CMD_DEQ1: r = pop_head(1'b1);
      tcf_pkg::CMD_OLDEST: begin
        if (occupancy[0] != 0 && occupancy[1] != 0) begin
          stamp_gap = stamp_mem[1][head_ptr[1]] - stamp_mem[0][head_ptr[0]];
          // gap in the upper half: class 1 head counts as older; zero gap goes to class 0
          r = pop_head(stamp_gap[STAMP_BITS-1]);
        end else if (occupancy[0] != 0) begin
          r = pop_head(1'b0);
        end else if (occupancy[1] != 0) begin
          r = pop_head(1'b1);
        end else begin
          r.cls    = 1'b0;
          r.status = tcf_pkg::STS_EMPTY;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        head_ptr[c]  = 0;
        tail_ptr[c]  = 0;
        occupancy[c] = 0;
      end
      next_stamp = '0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(run_command(in_command, in_item_class, in_payload_in));
      if (out_valid && out_ready) begin
        got.tag    = out_payload_out;
        got.cls    = out_class_out;
        got.status = out_status;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result item: tag %h class %0d status %0d",
                     $time, got.tag, got.cls, got.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.tag !== want.tag || got.cls !== want.cls || got.status !== want.status) begin
            if (fail_count < 10)
              $display("%0t: result mismatch: tag %h/%h class %0d/%0d status %0d/%0d (exp/got)",
                       $time, want.tag, got.tag, want.cls, got.cls, want.status, got.status);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/two_class_fifo_oldest_first_top_tb.sv]
// Testbench top for the two-class FIFO: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module two_class_fifo_oldest_first_top_tb;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int STAMP_BITS   = 8;
  localparam int ITEM_TARGET  = 850;

  typedef logic [PAYLOAD_BITS-1:0] tag_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent;
  logic in_quiet;

  tcf_in_if  #(.PAYLOAD_BITS(PAYLOAD_BITS)) in_if ();
  tcf_out_if #(.PAYLOAD_BITS(PAYLOAD_BITS)) out_if ();

  two_class_fifo_oldest_first_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  tcf_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_command     (in_if.command),
    .in_item_class  (in_if.item_class),
    .in_payload_in  (in_if.payload_in),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_payload_out(out_if.payload_out),
    .out_class_out  (out_if.class_out),
    .out_status     (out_if.status),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic [1:0] cmd, input logic cls, input tag_t tag);
    int gap;
    if (items_sent % 64 == 0)
      in_quiet = ($urandom_range(0, 3) == 0);
    gap = in_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.command    = cmd;
    in_if.item_class = cls;
    in_if.payload_in = tag;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    int   n;
    int   sel;
    int   r;
    logic c;
    logic aged;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.command    = tcf_pkg::CMD_ENQ;
    in_if.item_class = 1'b0;
    in_if.payload_in = '0;
    in_quiet         = 1'b0;
    items_sent       = 0;
    aged             = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // empty dequeues of every kind
    send_item(tcf_pkg::CMD_DEQ0, 1'b1, '1);
    send_item(tcf_pkg::CMD_DEQ1, 1'b0, '0);
    send_item(tcf_pkg::CMD_OLDEST, 1'b1, '1);
    // class 0 older, then class 1 older
    send_item(tcf_pkg::CMD_ENQ, 1'b0, '0);
    send_item(tcf_pkg::CMD_ENQ, 1'b1, '1);
    send_item(tcf_pkg::CMD_OLDEST, 1'b0, '0);
    send_item(tcf_pkg::CMD_OLDEST, 1'b1, '1);
    send_item(tcf_pkg::CMD_ENQ, 1'b1, tag_t'(16'hA5A5));
    send_item(tcf_pkg::CMD_ENQ, 1'b0, tag_t'(16'h5A5A));
    send_item(tcf_pkg::CMD_OLDEST, 1'b0, '0);
    // fill class 0 and overflow it once
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_item(tcf_pkg::CMD_ENQ, 1'b0, i[0] ? '1 : tag_t'(i));

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (!aged && items_sent > 200) begin
        // empty both classes, park one item in class 0, then churn class 1
        // until its stamps cross the half range and finally match the parked one
        repeat (2 * QUEUE_DEPTH + 1)
          send_item(tcf_pkg::CMD_OLDEST, 1'($urandom_range(0, 1)), tag_t'($urandom));
        send_item(tcf_pkg::CMD_ENQ, 1'b0, tag_t'($urandom));
        for (int k = 1; k < (1 << STAMP_BITS); k++) begin
          send_item(tcf_pkg::CMD_ENQ, 1'b1, tag_t'($urandom));
          // past half range the oldest pick lands on class 1
          send_item(k >= (1 << (STAMP_BITS - 1)) ? tcf_pkg::CMD_OLDEST : tcf_pkg::CMD_DEQ1,
                    1'($urandom_range(0, 1)), tag_t'($urandom));
        end
        send_item(tcf_pkg::CMD_ENQ, 1'b1, tag_t'($urandom));  // equal stamps: tie
        repeat (3)
          send_item(tcf_pkg::CMD_OLDEST, 1'($urandom_range(0, 1)), tag_t'($urandom));
        aged = 1'b1;
      end else if (sel < 5) begin
        n = $urandom_range(8, 40);
        repeat (n) begin
          r = $urandom_range(0, 7);
          send_item(r < 3 ? tcf_pkg::CMD_ENQ : r == 3 ? tcf_pkg::CMD_DEQ0 :
                    r == 4 ? tcf_pkg::CMD_DEQ1 : tcf_pkg::CMD_OLDEST,
                    1'($urandom_range(0, 1)), tag_t'($urandom));
        end
      end else if (sel < 7) begin
        c = 1'($urandom_range(0, 1));
        n = $urandom_range(14, 19);
        repeat (n) send_item(tcf_pkg::CMD_ENQ, c, tag_t'($urandom));
      end else begin
        n = $urandom_range(6, 34);
        repeat (n) begin
          r = $urandom_range(0, 3);
          send_item(r == 0 ? tcf_pkg::CMD_DEQ0 : r == 1 ? tcf_pkg::CMD_DEQ1 :
                    tcf_pkg::CMD_OLDEST,
                    1'($urandom_range(0, 1)), tag_t'($urandom));
        end
      end
    end
    in_if.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS two_class_fifo_oldest_first_top");
    end else begin
      $display("FAIL two_class_fifo_oldest_first_top");
    end
    $finish;
  end

  initial begin : result_sink
    int   stall;
    int   taken;
    logic out_quiet;
    out_if.ready = 1'b0;
    out_quiet    = 1'b0;
    taken        = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0)
        out_quiet = ($urandom_range(0, 3) == 0);
      stall = out_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // slowest legal run is well under a quarter of this
  initial begin : watchdog
    #5_000_000;
    $display("FAIL two_class_fifo_oldest_first_top");
    $finish;
  end

endmodule

[two_class_fifo_oldest_first_top.f]
rtl/tcf_pkg.sv
rtl/tcf_in_if.sv
rtl/tcf_out_if.sv
rtl/tcf_front.sv
rtl/tcf_back.sv
rtl/two_class_fifo_oldest_first_top.sv
tb/tcf_checker.sv
tb/two_class_fifo_oldest_first_top_tb.sv
